// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is asserted.
`define LCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define LCP_ASSERT_NEVER(name, cond, msg) \
  `LCP_ASSERT(name, !(cond), msg)

`endif

// ----- hw/rtl/lcp_pkg.sv -----
// Package: widths, gate codes, activation tables and helpers of the LSTM pointwise core.
`timescale 1ns / 1ps

package lcp_pkg;

  // Number format and geometry
  localparam int FRAC_BITS   = 12;
  localparam int STREAMS     = 16;
  localparam int UNITS       = 64;
  localparam int DATA_W      = 16;
  localparam int SUM_W       = DATA_W + 1;
  localparam int SLOT_W      = 10;
  localparam int STORE_DEPTH = 1 << SLOT_W;
  localparam int CELL_SLOTS  = (STREAMS * UNITS < STORE_DEPTH) ? STREAMS * UNITS : STORE_DEPTH;
  localparam int HID_W       = 14;
  localparam int DATA_MAX    = (1 << (DATA_W - 1)) - 1;
  localparam int DATA_MIN    = -(1 << (DATA_W - 1));
  localparam int HID_MAX     = (1 << (HID_W - 1)) - 1;
  localparam int HID_MIN     = -(1 << (HID_W - 1));
  localparam int ONE_GATE    = 1 << FRAC_BITS;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  // Activation tables
  localparam int ROM_SIZE   = 256;
  localparam int IDX_W      = 8;
  localparam int GATE_W     = FRAC_BITS + 2;
  localparam int IDX_U_W    = 20;
  localparam int IDX_SHIFT  = FRAC_BITS - 4;
  localparam int IDX_OFFSET = (8 << FRAC_BITS) + (1 << (FRAC_BITS - 5));

  // Datapath widths
  localparam int PF_W   = GATE_W + DATA_W;
  localparam int PIG_W  = 2 * GATE_W;
  localparam int ACC_W  = PF_W + 2;
  localparam int HP_W   = 2 * GATE_W;
  localparam int HACC_W = HP_W + 1;

  // Stages from input register to output register
  localparam int PIPE_DEPTH = 7;

  // Gate codes
  localparam int NUM_GATES = 4;
  localparam int GATE_I    = 0;
  localparam int GATE_F    = 1;
  localparam int GATE_O    = 2;
  localparam int GATE_G    = 3;

  typedef logic signed [GATE_W-1:0] gate_t;
  typedef logic [ROM_SIZE-1:0][GATE_W-1:0] rom_t;

  typedef struct packed {
    logic [NUM_GATES-1:0][IDX_W-1:0] idx;
    logic                            sat;
  } pre_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

  // Shift-subtract quotient, used only while building the tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(num / den) at FRAC_BITS fraction bits
  function automatic logic [63:0] ratio_q(input logic [63:0] num, input logic [63:0] den);
    return udiv64((num << (FRAC_BITS + 1)) + den, den << 1);
  endfunction

  // Entry k stands for x = -8 + k/16; exp(-j/16) built by repeated rounded products.
  function automatic rom_t build_rom(input logic want_tanh);
    logic [63:0] e [ROM_SIZE+1];
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] step;
    logic [63:0] t;
    logic [63:0] v;
    int          m;
    int          a;
    rom_t        rom;
    term = 64'd1 << 62;
    sum  = term;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term, 64'(16 * n));
      if ((n & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    step = (sum + (64'd1 << 30)) >> 31;
    e[0] = ONE_Q31;
    for (int j = 1; j <= ROM_SIZE; j++) begin
      e[j] = (e[j-1] * step + (64'd1 << 30)) >> 31;
    end
    for (int k = 0; k < ROM_SIZE; k++) begin
      m = k - ROM_SIZE / 2;
      a = (m < 0) ? -m : m;
      if (want_tanh) begin
        t = ratio_q(ONE_Q31 - e[2*a], ONE_Q31 + e[2*a]);
        v = (m < 0) ? -t : t;
      end else if (m >= 0) begin
        v = ratio_q(ONE_Q31, ONE_Q31 + e[a]);
      end else begin
        v = ratio_q(e[a], ONE_Q31 + e[a]);
      end
      rom[k] = GATE_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM  = build_rom(1'b0);
  localparam rom_t TANH_ROM = build_rom(1'b1);

  function automatic gate_t sig_lut(input logic [IDX_W-1:0] idx);
    return gate_t'(SIG_ROM[idx]);
  endfunction

  function automatic gate_t tanh_lut(input logic [IDX_W-1:0] idx);
    return gate_t'(TANH_ROM[idx]);
  endfunction

  // Table index: round(16*x) + 128, ties upward, clamped to the table.
  function automatic logic [IDX_W-1:0] rom_index(input logic signed [DATA_W-1:0] x);
    logic signed [IDX_U_W-1:0] u;
    logic        [IDX_U_W-1:0] sh;
    u  = IDX_U_W'(x) + IDX_U_W'(IDX_OFFSET);
    sh = IDX_U_W'(u >>> IDX_SHIFT);
    if (u < 0) return '0;
    else if (sh > IDX_U_W'(ROM_SIZE - 1)) return '1;
    else return sh[IDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/lcp_gate_pre.sv -----
// Gate preactivations, plus the recurrent terms when keep_i is set, with saturation and activation table indexing.
`timescale 1ns / 1ps

module lcp_gate_pre (
  input  logic                                           keep_i,
  input  logic [lcp_pkg::NUM_GATES-1:0][lcp_pkg::DATA_W-1:0] pre_i,
  input  logic [lcp_pkg::NUM_GATES-1:0][lcp_pkg::DATA_W-1:0] rec_i,
  output lcp_pkg::pre_t                                  pre_o
);

  logic signed [lcp_pkg::SUM_W-1:0]  sum [lcp_pkg::NUM_GATES];
  logic signed [lcp_pkg::DATA_W-1:0] val [lcp_pkg::NUM_GATES];
  logic [lcp_pkg::NUM_GATES-1:0]     ovf;

  always_comb begin
    for (int q = 0; q < lcp_pkg::NUM_GATES; q++) begin
      sum[q] = lcp_pkg::SUM_W'($signed(pre_i[q])) + lcp_pkg::SUM_W'($signed(rec_i[q]));
      ovf[q] = 1'b0;
      if (!keep_i) begin
        val[q] = $signed(pre_i[q]);
      end else if (sum[q] > lcp_pkg::SUM_W'(lcp_pkg::DATA_MAX)) begin
        val[q] = lcp_pkg::DATA_W'(lcp_pkg::DATA_MAX);
        ovf[q] = 1'b1;
      end else if (sum[q] < lcp_pkg::SUM_W'(lcp_pkg::DATA_MIN)) begin
        val[q] = lcp_pkg::DATA_W'(lcp_pkg::DATA_MIN);
        ovf[q] = 1'b1;
      end else begin
        val[q] = lcp_pkg::DATA_W'(sum[q]);
      end
      pre_o.idx[q] = lcp_pkg::rom_index(val[q]);
    end
    pre_o.sat = |ovf;
  end

endmodule

// ----- hw/rtl/lcp_cell_mem.sv -----
// Cell value store: one write port, one registered read port, zeroing sweep after reset.
`timescale 1ns / 1ps

module lcp_cell_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [lcp_pkg::SLOT_W-1:0]  rd_addr_i,
  input  lcp_pkg::mem_wr_t            wr_i,
  output logic [lcp_pkg::DATA_W-1:0]  rd_data_o,
  output logic                        ready_o
);

  logic [lcp_pkg::DATA_W-1:0] mem_q [lcp_pkg::STORE_DEPTH];
  logic [lcp_pkg::DATA_W-1:0] rd_data_q;
  logic [lcp_pkg::SLOT_W-1:0] clr_cnt_q;
  logic                       clr_busy_q;

  // Sweep every entry to zero, one per cycle, before taking traffic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == lcp_pkg::SLOT_W'(lcp_pkg::STORE_DEPTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) mem_q[clr_cnt_q] <= '0;
    else if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_busy_q;

endmodule

// ----- hw/rtl/lstm_cell_pointwise_forward_core.sv -----
// Top level: pipelined LSTM cell pointwise update around the cell value store.
`timescale 1ns / 1ps

// The core takes one hidden unit per clock: four gate preactivations, four
// recurrent terms, a continue flag and a cell slot, and returns h in Q2.12
// and the new cell value c in Q4.12. The previous cell value is read from a
// 1024 x 16 synchronous store at the edge the item is accepted and the new
// value is written back as the item leaves stage C, so an item whose slot
// matches one of the (up to) three items still ahead of the write-back is held
// off until that write lands; with slots rotating over units the core sustains
// one item per cycle. After reset the store is swept to zero, one entry per
// cycle, and no item is taken until the sweep is done. A stalled result sits
// in the output register while the stages behind it keep filling.
//
// Stages: A gate indices and store read data, B activation lookups and cell
// operand select, C f*c_prev and i*g, D rounded c (written back), E tanh(c),
// F o*tanh(c), then the output register.

module lstm_cell_pointwise_forward_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lcp_pkg::SLOT_W-1:0]         slot_i,
  input  logic                               keep_state_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  pre_in_i_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  pre_in_f_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  pre_in_o_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  pre_in_g_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  rec_i_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  rec_f_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  rec_o_i,
  input  logic signed [lcp_pkg::DATA_W-1:0]  rec_g_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lcp_pkg::HID_W-1:0]   hidden_out_o,
  output logic signed [lcp_pkg::DATA_W-1:0]  cell_out_o,
  output logic                               sat_flag_o
);

  // ---------------------------------------------------------------------------
  // Stage enables: a stage advances when empty or when the next one advances,
  // so bubbles collapse and input keeps flowing behind a stalled result.
  // ---------------------------------------------------------------------------
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;
  logic in_fire, in_inr, hazard, mem_ready;

  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q, f_valid_q, out_valid_q;

  assign en_o = !out_valid_q || !out_stall_i;
  assign en_f = !f_valid_q || en_o;
  assign en_e = !e_valid_q || en_f;
  assign en_d = !d_valid_q || en_e;
  assign en_c = !c_valid_q || en_d;
  assign en_b = !b_valid_q || en_c;
  assign en_a = !a_valid_q || en_b;

  // ---------------------------------------------------------------------------
  // Front end: saturated gate sums and table indices straight off the ports.
  // ---------------------------------------------------------------------------
  logic [lcp_pkg::NUM_GATES-1:0][lcp_pkg::DATA_W-1:0] pre_vec;
  logic [lcp_pkg::NUM_GATES-1:0][lcp_pkg::DATA_W-1:0] rec_vec;
  lcp_pkg::pre_t                                      pre;

  assign pre_vec[lcp_pkg::GATE_I] = pre_in_i_i;
  assign pre_vec[lcp_pkg::GATE_F] = pre_in_f_i;
  assign pre_vec[lcp_pkg::GATE_O] = pre_in_o_i;
  assign pre_vec[lcp_pkg::GATE_G] = pre_in_g_i;
  assign rec_vec[lcp_pkg::GATE_I] = rec_i_i;
  assign rec_vec[lcp_pkg::GATE_F] = rec_f_i;
  assign rec_vec[lcp_pkg::GATE_O] = rec_o_i;
  assign rec_vec[lcp_pkg::GATE_G] = rec_g_i;

  lcp_gate_pre u_gate_pre (
    .keep_i (keep_state_i),
    .pre_i  (pre_vec),
    .rec_i  (rec_vec),
    .pre_o  (pre)
  );

  // Slots past the configured streams read zero and are never written.
  assign in_inr = int'(slot_i) < lcp_pkg::CELL_SLOTS;

  // ---------------------------------------------------------------------------
  // Pipeline payload registers
  // ---------------------------------------------------------------------------
  logic [lcp_pkg::SLOT_W-1:0]                         a_slot_q, b_slot_q, c_slot_q;
  logic                                               a_inr_q, b_inr_q, c_inr_q;
  logic                                               a_keep_q;
  logic [lcp_pkg::NUM_GATES-1:0][lcp_pkg::IDX_W-1:0]  a_idx_q;
  logic                                               a_sat_q, b_sat_q, c_sat_q;
  logic                                               d_sat_q, e_sat_q, f_sat_q;
  lcp_pkg::gate_t                                     b_gi_q, b_gf_q, b_go_q, b_gg_q;
  lcp_pkg::gate_t                                     c_go_q, d_go_q, e_go_q, e_th_q;
  logic signed [lcp_pkg::DATA_W-1:0]                  b_cprev_q;
  logic signed [lcp_pkg::PF_W-1:0]                    c_pf_q;
  logic signed [lcp_pkg::PIG_W-1:0]                   c_pig_q;
  logic signed [lcp_pkg::DATA_W-1:0]                  d_c_q, e_c_q, f_c_q;
  logic signed [lcp_pkg::HP_W-1:0]                    f_prod_q;
  logic signed [lcp_pkg::HID_W-1:0]                   hidden_q;
  logic signed [lcp_pkg::DATA_W-1:0]                  cell_q;
  logic                                               sat_q;

  // ---------------------------------------------------------------------------
  // Read-after-write interlock: items in A, B and C have not written back yet,
  // so hold off an item whose slot matches any of them.
  // ---------------------------------------------------------------------------
  assign hazard = in_inr && ((a_valid_q && a_inr_q && (a_slot_q == slot_i)) ||
                             (b_valid_q && b_inr_q && (b_slot_q == slot_i)) ||
                             (c_valid_q && c_inr_q && (c_slot_q == slot_i)));

  assign in_stall_o = !en_a || hazard || !mem_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Cell store: read at accept, written when the item leaves stage C.
  // ---------------------------------------------------------------------------
  logic signed [lcp_pkg::DATA_W-1:0] c_val;
  logic                              c_ovf;
  logic [lcp_pkg::DATA_W-1:0]        rd_data;
  lcp_pkg::mem_wr_t                  mem_wr;

  assign mem_wr.en   = c_valid_q && c_inr_q && en_d;
  assign mem_wr.addr = c_slot_q;
  assign mem_wr.data = c_val;

  lcp_cell_mem u_cell_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (en_a),
    .rd_addr_i (slot_i),
    .wr_i      (mem_wr),
    .rd_data_o (rd_data),
    .ready_o   (mem_ready)
  );

  // ---------------------------------------------------------------------------
  // Stage C arithmetic: c = round(f*c_prev + i*g), saturated to 16 bits.
  // ---------------------------------------------------------------------------
  logic signed [lcp_pkg::ACC_W-1:0] c_acc;
  logic signed [lcp_pkg::ACC_W-1:0] c_rnd;

  always_comb begin
    c_acc = lcp_pkg::ACC_W'(c_pf_q) + lcp_pkg::ACC_W'(c_pig_q) +
            lcp_pkg::ACC_W'(lcp_pkg::ROUND_HALF);
    c_rnd = c_acc >>> lcp_pkg::FRAC_BITS;
    c_ovf = 1'b0;
    if (c_rnd > lcp_pkg::ACC_W'(lcp_pkg::DATA_MAX)) begin
      c_val = lcp_pkg::DATA_W'(lcp_pkg::DATA_MAX);
      c_ovf = 1'b1;
    end else if (c_rnd < lcp_pkg::ACC_W'(lcp_pkg::DATA_MIN)) begin
      c_val = lcp_pkg::DATA_W'(lcp_pkg::DATA_MIN);
      c_ovf = 1'b1;
    end else begin
      c_val = lcp_pkg::DATA_W'(c_rnd);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F arithmetic: h = round(o*tanh(c)), clamped to the hidden field.
  // ---------------------------------------------------------------------------
  logic signed [lcp_pkg::HACC_W-1:0] f_acc;
  logic signed [lcp_pkg::HACC_W-1:0] f_rnd;
  logic signed [lcp_pkg::HID_W-1:0]  h_val;

  always_comb begin
    f_acc = lcp_pkg::HACC_W'(f_prod_q) + lcp_pkg::HACC_W'(lcp_pkg::ROUND_HALF);
    f_rnd = f_acc >>> lcp_pkg::FRAC_BITS;
    if (f_rnd > lcp_pkg::HACC_W'(lcp_pkg::HID_MAX)) begin
      h_val = lcp_pkg::HID_W'(lcp_pkg::HID_MAX);
    end else if (f_rnd < lcp_pkg::HACC_W'(lcp_pkg::HID_MIN)) begin
      h_val = lcp_pkg::HID_W'(lcp_pkg::HID_MIN);
    end else begin
      h_val = lcp_pkg::HID_W'(f_rnd);
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) a_valid_q <= in_fire;
      if (en_b) b_valid_q <= a_valid_q;
      if (en_c) c_valid_q <= b_valid_q;
      if (en_d) d_valid_q <= c_valid_q;
      if (en_e) e_valid_q <= d_valid_q;
      if (en_f) f_valid_q <= e_valid_q;
      if (en_o) out_valid_q <= f_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload: advance each stage with its enable, no reset needed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // A: capture slot, flags and table indices
    if (en_a) begin
      a_slot_q <= slot_i;
      a_inr_q  <= in_inr;
      a_keep_q <= keep_state_i;
      a_idx_q  <= pre.idx;
      a_sat_q  <= pre.sat;
    end
    // B: look up the gates; drop the forget gate at the start of a sequence
    if (en_b) begin
      b_slot_q  <= a_slot_q;
      b_inr_q   <= a_inr_q;
      b_sat_q   <= a_sat_q;
      b_gi_q    <= lcp_pkg::sig_lut(a_idx_q[lcp_pkg::GATE_I]);
      b_gf_q    <= a_keep_q ? lcp_pkg::sig_lut(a_idx_q[lcp_pkg::GATE_F]) : '0;
      b_go_q    <= lcp_pkg::sig_lut(a_idx_q[lcp_pkg::GATE_O]);
      b_gg_q    <= lcp_pkg::tanh_lut(a_idx_q[lcp_pkg::GATE_G]);
      b_cprev_q <= a_inr_q ? $signed(rd_data) : '0;
    end
    // C: the two products
    if (en_c) begin
      c_slot_q <= b_slot_q;
      c_inr_q  <= b_inr_q;
      c_sat_q  <= b_sat_q;
      c_go_q   <= b_go_q;
      c_pf_q   <= lcp_pkg::PF_W'(b_gf_q) * lcp_pkg::PF_W'(b_cprev_q);
      c_pig_q  <= lcp_pkg::PIG_W'(b_gi_q) * lcp_pkg::PIG_W'(b_gg_q);
    end
    // D: rounded, saturated cell value
    if (en_d) begin
      d_sat_q <= c_sat_q | c_ovf;
      d_go_q  <= c_go_q;
      d_c_q   <= c_val;
    end
    // E: tanh of the new cell value
    if (en_e) begin
      e_sat_q <= d_sat_q;
      e_go_q  <= d_go_q;
      e_c_q   <= d_c_q;
      e_th_q  <= lcp_pkg::tanh_lut(lcp_pkg::rom_index(d_c_q));
    end
    // F: output gate product
    if (en_f) begin
      f_sat_q  <= e_sat_q;
      f_c_q    <= e_c_q;
      f_prod_q <= lcp_pkg::HP_W'(e_go_q) * lcp_pkg::HP_W'(e_th_q);
    end
    // Output register: hold while stalled
    if (en_o) begin
      hidden_q <= h_val;
      cell_q   <= f_c_q;
      sat_q    <= f_sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hidden_out_o = hidden_q;
  assign cell_out_o   = cell_q;
  assign sat_flag_o   = sat_q;

endmodule

// ----- hw/rtl/lcp_checker.sv -----
// Port-level checker for the LSTM pointwise core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_o,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [lcp_pkg::HID_W-1:0]   hidden_out_o,
  input  logic signed [lcp_pkg::DATA_W-1:0]  cell_out_o,
  input  logic                               sat_flag_o
);

  localparam int CNT_W = $clog2(lcp_pkg::PIPE_DEPTH + 1) + 1;

  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] cnt_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // Items accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire && !out_fire) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  `LCP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(hidden_out_o) && $stable(cell_out_o) && $stable(sat_flag_o), "stalled result changed")
  `LCP_ASSERT(a_hidden_range, out_valid_o |-> (hidden_out_o >= -lcp_pkg::ONE_GATE) && (hidden_out_o <= lcp_pkg::ONE_GATE), "hidden value out of range")
  `LCP_ASSERT(a_no_orphan, out_fire |-> (cnt_q != '0), "result without an item in flight")
  `LCP_ASSERT_NEVER(a_depth, cnt_q > CNT_W'(lcp_pkg::PIPE_DEPTH), "more items in flight than stages")

endmodule

bind lstm_cell_pointwise_forward_core lcp_checker u_lcp_checker (.*);
